FILE: rtl/core/soa_pkg.sv
// package for the slab object allocator
// holds beat structs, operation and status codes, state encoding and sizes
// no dependencies
package soa_pkg;

    localparam int MAX_SLABS  = 16;
    localparam int PAGE_BYTES = 4096;
    localparam int MIN_STRIDE = 4;
    localparam int MAX_OBJS   = PAGE_BYTES / MIN_STRIDE;
    localparam int SLAB_W     = $clog2(MAX_SLABS);
    localparam int OBJ_W      = $clog2(MAX_OBJS);
    localparam int CNT_W      = OBJ_W + 1;
    localparam int ADDR_W     = SLAB_W + OBJ_W;
    localparam int STRIDE_W   = 17;
    localparam int PAGE_W     = $clog2(PAGE_BYTES);
    localparam int DIV_W      = PAGE_W + 1;
    localparam int REL_W      = 5;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RECLAIM = 2'd2;
    localparam logic [1:0] OP_DESTROY = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE  = 2'd2;

    localparam logic [1:0] CFG_OBJECT_SIZE = 2'd0;
    localparam logic [1:0] CFG_ALIGN_LOG2  = 2'd1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  slab_id;
        logic [9:0]  object_index;
        logic [4:0]  reclaim_target;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  granted_slab;
        logic [9:0]  granted_index;
        logic [11:0] byte_offset;
        logic [4:0]  slabs_released;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_CREATE,
        S_FILL,
        S_READ,
        S_POP,
        S_RECL,
        S_FIN,
        S_DIV
    } t_state;

endpackage

FILE: rtl/core/slab_object_allocator.sv
// top level of the slab object allocator
// sequencer, slab table, link memory and capacity divider; uses soa_pkg
//
// usage: requests arrive as beats on the in channel (valid/ready) and each
// request gives one result beat on the out channel (valid/ready).
// a free or a destroy is carried out in the exec step and then finishes; an
// allocate that finds a slab scans all 16 slab table entries, one entry per
// cycle, then reads and pops the link memory; an allocate that has to create
// a slab adds a create step and a fill, since the new slab's free list is
// written into the link memory one entry a cycle; a reclaim walks the ranks,
// one rank a cycle. one request is in flight at a time.
// a config write starts a restoring division of the page size by the
// stride, one quotient bit a cycle; no request is taken meanwhile.
// reset clears the slab table and loads the default size and alignment
// (stride 64, capacity 64); the link memory needs no clearing.
// a finished result sits in the output register; a stalled receiver only
// holds the sequencer at its last step, and the next request may be taken
// once the result is handed to the output register.
module slab_object_allocator (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  soa_pkg::t_in_beat        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output soa_pkg::t_out_beat       o_out_data,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [12:0]              i_cfg_data
);

    localparam int NS = soa_pkg::MAX_SLABS;
    localparam int SW = soa_pkg::SLAB_W;
    localparam int OW = soa_pkg::OBJ_W;
    localparam int CW = soa_pkg::CNT_W;
    localparam int TW = soa_pkg::STRIDE_W;
    localparam int DW = soa_pkg::DIV_W;
    localparam int RW = soa_pkg::REL_W;

    soa_pkg::t_state r_state, n_state;

    // slab table
    logic [NS-1:0] r_live, n_live;
    logic [SW-1:0] r_rank  [NS];
    logic [SW-1:0] n_rank  [NS];
    logic [OW-1:0] r_head  [NS];
    logic [OW-1:0] n_head  [NS];
    logic [CW-1:0] r_total [NS];
    logic [CW-1:0] n_total [NS];

    // geometry
    logic [12:0]   r_size, n_size;
    logic [3:0]    r_align, n_align;
    logic [TW-1:0] r_stride, n_stride;
    logic [CW-1:0] r_cap, n_cap;
    logic [TW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;

    // sequencer working registers
    soa_pkg::t_in_beat  r_req, n_req;
    soa_pkg::t_out_beat r_res, n_res;
    soa_pkg::t_out_beat r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_bestv, n_bestv;
    logic [SW-1:0]      r_best, n_best;
    logic [SW-1:0]      r_kept, n_kept;
    logic [RW-1:0]      r_rel, n_rel;

    // link memory
    logic [OW-1:0]                 r_link [2**soa_pkg::ADDR_W];
    logic [OW-1:0]                 r_rdata;
    logic                          mem_we;
    logic [soa_pkg::ADDR_W-1:0]    mem_waddr;
    logic [OW-1:0]                 mem_wdata;
    logic                          mem_re;
    logic [soa_pkg::ADDR_W-1:0]    mem_raddr;

    // helper signals
    logic          cfg_hit;
    logic [12:0]   cfg_size;
    logic [3:0]    cfg_align;
    logic [TW-1:0] new_stride;
    logic [TW-1:0] a_mask;
    logic [TW-1:0] a_sum;
    logic          scan_hit;
    logic [SW-1:0] scan_idx;
    logic          slot_found;
    logic [SW-1:0] slot_idx;
    logic          m_hit;
    logic [SW-1:0] m_idx;
    logic          free_ok;
    logic [RW-1:0] live_count;
    logic [TW-1:0] div_shift;
    logic          in_fire;
    logic          fin_go;
    logic [21:0]   off_prod;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == soa_pkg::S_IDLE) && !i_cfg_we;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign fin_go      = !r_out_valid || i_out_ready;
    assign cfg_hit     = i_cfg_we && ((i_cfg_index == soa_pkg::CFG_OBJECT_SIZE) ||
                                      (i_cfg_index == soa_pkg::CFG_ALIGN_LOG2));

    // stride from the incoming register values
    always_comb begin
        if (i_cfg_index == soa_pkg::CFG_OBJECT_SIZE) begin
            cfg_size  = i_cfg_data;
            cfg_align = r_align;
        end else begin
            cfg_size  = r_size;
            cfg_align = i_cfg_data[3:0];
        end
        a_mask = (TW'(1) << cfg_align) - TW'(1);
        a_sum  = TW'(cfg_size) + a_mask;
        new_stride = a_sum & ~a_mask;
        if (new_stride < TW'(soa_pkg::MIN_STRIDE)) begin
            new_stride = TW'(soa_pkg::MIN_STRIDE);
        end
    end

    // table lookups shared by the sequencer steps
    always_comb begin
        scan_idx = r_cnt[SW-1:0];
        scan_hit = r_live[scan_idx] && (r_total[scan_idx] != '0) &&
                   (!r_bestv || (r_rank[scan_idx] < r_rank[r_best]));
        slot_found = 1'b0;
        slot_idx   = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (!r_live[i]) begin
                slot_found = 1'b1;
                slot_idx   = SW'(i);
            end
        end
        m_hit = 1'b0;
        m_idx = '0;
        for (int i = 0; i < NS; i++) begin
            if (r_live[i] && (r_rank[i] == r_cnt[SW-1:0])) begin
                m_hit = 1'b1;
                m_idx = SW'(i);
            end
        end
        live_count = '0;
        for (int i = 0; i < NS; i++) begin
            live_count = live_count + RW'(r_live[i]);
        end
        free_ok = r_live[r_req.slab_id] &&
                  (CW'(r_req.object_index) < r_cap) &&
                  (r_total[r_req.slab_id] < r_cap);
        div_shift = {r_rem[TW-2:0], (r_cnt[3:0] == 4'(DW - 1))};
        off_prod  = r_head[r_best] * r_stride[11:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            soa_pkg::S_IDLE: begin
                if (in_fire) n_state = soa_pkg::S_EXEC;
            end
            soa_pkg::S_EXEC: begin
                unique case (r_req.operation)
                    soa_pkg::OP_ALLOC:
                        n_state = (r_cap == '0) ? soa_pkg::S_FIN : soa_pkg::S_SCAN;
                    soa_pkg::OP_RECLAIM: n_state = soa_pkg::S_RECL;
                    default:             n_state = soa_pkg::S_FIN;
                endcase
            end
            soa_pkg::S_SCAN: begin
                if (r_cnt[SW-1:0] == SW'(NS - 1)) begin
                    n_state = (r_bestv || scan_hit) ? soa_pkg::S_READ : soa_pkg::S_CREATE;
                end
            end
            soa_pkg::S_CREATE: begin
                n_state = slot_found ? soa_pkg::S_FILL : soa_pkg::S_FIN;
            end
            soa_pkg::S_FILL: begin
                if (r_cnt == r_cap - CW'(1)) n_state = soa_pkg::S_READ;
            end
            soa_pkg::S_READ: n_state = soa_pkg::S_POP;
            soa_pkg::S_POP:  n_state = soa_pkg::S_FIN;
            soa_pkg::S_RECL: begin
                if (r_cnt[SW-1:0] == SW'(NS - 1)) n_state = soa_pkg::S_FIN;
            end
            soa_pkg::S_FIN: begin
                if (fin_go) n_state = soa_pkg::S_IDLE;
            end
            soa_pkg::S_DIV: begin
                if (r_cnt[3:0] == 4'd0) n_state = soa_pkg::S_IDLE;
            end
            default: n_state = soa_pkg::S_IDLE;
        endcase
        if (cfg_hit) n_state = soa_pkg::S_DIV;
    end

    // datapath and table updates
    always_comb begin
        n_live      = r_live;
        n_rank      = r_rank;
        n_head      = r_head;
        n_total     = r_total;
        n_size      = r_size;
        n_align     = r_align;
        n_stride    = r_stride;
        n_cap       = r_cap;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_cnt       = r_cnt;
        n_bestv     = r_bestv;
        n_best      = r_best;
        n_kept      = r_kept;
        n_rel       = r_rel;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        // output beat handed off
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        unique case (r_state)
            soa_pkg::S_IDLE: begin
                if (in_fire) n_req = i_in_data;
            end
            soa_pkg::S_EXEC: begin
                n_res   = '0;
                n_cnt   = '0;
                n_bestv = 1'b0;
                n_kept  = '0;
                n_rel   = '0;
                unique case (r_req.operation)
                    soa_pkg::OP_ALLOC: begin
                        if (r_cap == '0) n_res.status = soa_pkg::ST_NO_SLOT;
                    end
                    soa_pkg::OP_FREE: begin
                        if (free_ok) begin
                            mem_we    = 1'b1;
                            mem_waddr = {r_req.slab_id, r_req.object_index};
                            mem_wdata = r_head[r_req.slab_id];
                            n_head[r_req.slab_id]  = r_req.object_index;
                            n_total[r_req.slab_id] = r_total[r_req.slab_id] + CW'(1);
                        end else begin
                            n_res.status = soa_pkg::ST_BAD_FREE;
                        end
                    end
                    soa_pkg::OP_RECLAIM: begin
                    end
                    default: begin
                        n_res.slabs_released = live_count;
                        n_live = '0;
                        for (int i = 0; i < NS; i++) begin
                            n_rank[i]  = '0;
                            n_total[i] = '0;
                        end
                    end
                endcase
            end
            // newest slab with a free slot, one entry a cycle
            soa_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_bestv = 1'b1;
                    n_best  = scan_idx;
                end
                n_cnt = r_cnt + CW'(1);
            end
            // new slab takes rank zero, the others age by one
            soa_pkg::S_CREATE: begin
                if (slot_found) begin
                    for (int i = 0; i < NS; i++) begin
                        if (r_live[i]) n_rank[i] = r_rank[i] + SW'(1);
                    end
                    n_live[slot_idx]  = 1'b1;
                    n_rank[slot_idx]  = '0;
                    n_total[slot_idx] = r_cap;
                    n_head[slot_idx]  = OW'(r_cap - CW'(1));
                    n_best            = slot_idx;
                    n_cnt             = '0;
                end else begin
                    n_res.status = soa_pkg::ST_NO_SLOT;
                end
            end
            // free list of a new slab, highest index first
            soa_pkg::S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = {r_best, r_cnt[OW-1:0]};
                mem_wdata = (r_cnt == '0) ? '0 : OW'(r_cnt - CW'(1));
                n_cnt     = r_cnt + CW'(1);
            end
            soa_pkg::S_READ: begin
                mem_re    = 1'b1;
                mem_raddr = {r_best, r_head[r_best]};
            end
            // pop the list head
            soa_pkg::S_POP: begin
                n_head[r_best]      = r_rdata;
                n_total[r_best]     = r_total[r_best] - CW'(1);
                n_res.granted_slab  = r_best;
                n_res.granted_index = r_head[r_best];
                n_res.byte_offset   = off_prod[11:0];
            end
            // one rank a cycle: release empty slabs up to the target, compact the rest
            soa_pkg::S_RECL: begin
                if (m_hit) begin
                    if ((r_rel < r_req.reclaim_target) && (r_total[m_idx] == r_cap)) begin
                        n_live[m_idx]  = 1'b0;
                        n_total[m_idx] = '0;
                        n_rank[m_idx]  = '0;
                        n_rel          = r_rel + RW'(1);
                    end else begin
                        n_rank[m_idx] = r_kept;
                        n_kept        = r_kept + SW'(1);
                    end
                end
                n_cnt = r_cnt + CW'(1);
            end
            soa_pkg::S_FIN: begin
                if (fin_go) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    if (r_req.operation == soa_pkg::OP_RECLAIM) begin
                        n_out.slabs_released = r_rel;
                    end
                end
            end
            // restoring division of the page size by the stride
            soa_pkg::S_DIV: begin
                if (div_shift >= r_stride) begin
                    n_rem = div_shift - r_stride;
                    n_quo = {r_quo[DW-2:0], 1'b1};
                end else begin
                    n_rem = div_shift;
                    n_quo = {r_quo[DW-2:0], 1'b0};
                end
                n_cnt = r_cnt - CW'(1);
                if (r_cnt[3:0] == 4'd0) begin
                    n_cap = (r_size == '0) ? '0 : n_quo[CW-1:0];
                end
            end
            default: begin
            end
        endcase

        // config write restarts the geometry
        if (cfg_hit) begin
            if (i_cfg_index == soa_pkg::CFG_OBJECT_SIZE) begin
                n_size = i_cfg_data;
            end else begin
                n_align = i_cfg_data[3:0];
            end
            n_stride = new_stride;
            n_rem    = '0;
            n_quo    = '0;
            n_cnt    = CW'(DW - 1);
        end
    end

    // control and table registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= soa_pkg::S_IDLE;
            r_live      <= '0;
            r_out_valid <= 1'b0;
            r_size      <= 13'd64;
            r_align     <= 4'd4;
            r_stride    <= TW'(64);
            r_cap       <= CW'(64);
            r_bestv     <= 1'b0;
            r_cnt       <= '0;
            for (int i = 0; i < NS; i++) begin
                r_rank[i]  <= '0;
                r_total[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
            r_size      <= n_size;
            r_align     <= n_align;
            r_stride    <= n_stride;
            r_cap       <= n_cap;
            r_bestv     <= n_bestv;
            r_cnt       <= n_cnt;
            r_rank      <= n_rank;
            r_total     <= n_total;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_req  <= n_req;
        r_res  <= n_res;
        r_out  <= n_out;
        r_best <= n_best;
        r_kept <= n_kept;
        r_rel  <= n_rel;
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_link[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) r_rdata <= r_link[mem_raddr];
    end

endmodule

FILE: sim/tb_slab_object_allocator.sv
// testbench for the slab object allocator: random and directed requests,
// results checked against a behavioral model of the slab cache
// depends on soa_pkg and slab_object_allocator
`timescale 1ns / 100ps

module tb_slab_object_allocator;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int NSLAB = soa_pkg::MAX_SLABS;
    localparam int NOBJ  = soa_pkg::MAX_OBJS;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    soa_pkg::t_in_beat   i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    soa_pkg::t_out_beat  o_out_data;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [12:0]         i_cfg_data;

    slab_object_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // cache model state
    logic [12:0] m_size;
    logic [3:0]  m_align;
    int unsigned m_stride;
    int unsigned m_cap;
    bit          m_live[NSLAB];
    int unsigned m_rank[NSLAB];
    int unsigned m_head[NSLAB];
    int unsigned m_avail[NSLAB];
    int unsigned m_link[NSLAB*NOBJ];

    soa_pkg::t_out_beat pending_results[$];
    int          errors;
    int          beats_sent;
    int          beats_checked;
    int          idle_cycles;
    bit          stall_enable;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void geometry_update();
        int unsigned a;
        int unsigned s;
        a = 1 << m_align;
        s = (m_size + a - 1) & ~(a - 1);
        if (s < soa_pkg::MIN_STRIDE) s = soa_pkg::MIN_STRIDE;
        m_stride = s;
        m_cap = (m_size == 0) ? 0 : soa_pkg::PAGE_BYTES / s;
    endfunction

    function automatic void cache_clear();
        for (int i = 0; i < NSLAB; i++) begin
            m_live[i] = 0;
            m_rank[i] = 0;
            m_head[i] = 0;
            m_avail[i] = 0;
        end
    endfunction

    function automatic int slab_open();
        int s;
        s = -1;
        for (int i = 0; i < NSLAB; i++)
            if (!m_live[i] && s < 0) s = i;
        if (s < 0) return -1;
        for (int i = 0; i < NSLAB; i++)
            if (m_live[i]) m_rank[i]++;
        m_live[s] = 1;
        m_rank[s] = 0;
        m_avail[s] = m_cap;
        m_head[s] = m_cap - 1;
        for (int i = 0; i < m_cap; i++)
            m_link[s*NOBJ + i] = (i != 0) ? i - 1 : 0;
        return s;
    endfunction

    // predicted result of one request, updating the model
    function automatic soa_pkg::t_out_beat cache_predict(soa_pkg::t_in_beat req);
        soa_pkg::t_out_beat res;
        int          best;
        int unsigned idx;
        int unsigned rel;
        int unsigned newr[NSLAB];
        res = '0;
        rel = 0;
        case (req.operation)
            soa_pkg::OP_ALLOC: begin
                best = -1;
                if (m_cap != 0) begin
                    for (int i = 0; i < NSLAB; i++)
                        if (m_live[i] && m_avail[i] > 0 &&
                            (best < 0 || m_rank[i] < m_rank[best]))
                            best = i;
                    if (best < 0) best = slab_open();
                end
                if (best < 0) begin
                    res.status = soa_pkg::ST_NO_SLOT;
                end else begin
                    idx = m_head[best];
                    if (idx >= NOBJ) idx = 0;
                    m_head[best] = m_link[best*NOBJ + idx];
                    m_avail[best]--;
                    res.granted_slab = 4'(best);
                    res.granted_index = 10'(idx);
                    res.byte_offset = 12'(idx * m_stride);
                end
            end
            soa_pkg::OP_FREE: begin
                if (!m_live[req.slab_id] || req.object_index >= m_cap ||
                    m_avail[req.slab_id] >= m_cap) begin
                    res.status = soa_pkg::ST_BAD_FREE;
                end else begin
                    m_link[req.slab_id*NOBJ + req.object_index] = m_head[req.slab_id];
                    m_head[req.slab_id] = req.object_index;
                    m_avail[req.slab_id]++;
                end
            end
            soa_pkg::OP_RECLAIM: begin
                for (int r = 0; r < NSLAB && rel < req.reclaim_target; r++) begin
                    for (int i = 0; i < NSLAB; i++) begin
                        if (m_live[i] && m_rank[i] == r) begin
                            if (m_avail[i] == m_cap) begin
                                m_live[i] = 0;
                                m_avail[i] = 0;
                                rel++;
                            end
                            break;
                        end
                    end
                end
                for (int i = 0; i < NSLAB; i++) begin
                    newr[i] = 0;
                    if (m_live[i])
                        for (int j = 0; j < NSLAB; j++)
                            if (m_live[j] && m_rank[j] < m_rank[i]) newr[i]++;
                end
                for (int i = 0; i < NSLAB; i++) m_rank[i] = newr[i];
            end
            default: begin
                for (int i = 0; i < NSLAB; i++)
                    if (m_live[i]) rel++;
                cache_clear();
            end
        endcase
        res.slabs_released = 5'(rel);
        return res;
    endfunction

    // send one request beat after a random gap
    task automatic send_req(input logic [1:0] op, input int unsigned sid,
                            input int unsigned oidx, input int unsigned tgt);
        soa_pkg::t_in_beat req;
        int unsigned gap;
        req.operation = op;
        req.slab_id = 4'(sid);
        req.object_index = 10'(oidx);
        req.reclaim_target = 5'(tgt);
        gap = gap_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(cache_predict(req));
        beats_sent++;
    endtask

    // free a slot that is most likely in use
    task automatic send_free_live();
        int unsigned s;
        s = $urandom_range(0, NSLAB - 1);
        for (int k = 0; k < NSLAB; k++)
            if (!m_live[s]) s = (s + 1) % NSLAB;
        send_req(soa_pkg::OP_FREE, s, (m_cap > 0) ? $urandom_range(0, m_cap - 1) : 0, 0);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        wait_drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == soa_pkg::CFG_OBJECT_SIZE) m_size = val;
        else m_align = val[3:0];
        geometry_update();
        repeat (20) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        soa_pkg::t_out_beat exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no request outstanding");
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                beats_checked++;
                if (o_out_data.status !== exp_res.status) begin
                    $error("status exp %0d got %0d", exp_res.status, o_out_data.status);
                    errors++;
                end
                if (o_out_data.granted_slab !== exp_res.granted_slab) begin
                    $error("granted_slab exp %0d got %0d",
                           exp_res.granted_slab, o_out_data.granted_slab);
                    errors++;
                end
                if (o_out_data.granted_index !== exp_res.granted_index) begin
                    $error("granted_index exp %0d got %0d",
                           exp_res.granted_index, o_out_data.granted_index);
                    errors++;
                end
                if (o_out_data.byte_offset !== exp_res.byte_offset) begin
                    $error("byte_offset exp %0d got %0d",
                           exp_res.byte_offset, o_out_data.byte_offset);
                    errors++;
                end
                if (o_out_data.slabs_released !== exp_res.slabs_released) begin
                    $error("slabs_released exp %0d got %0d",
                           exp_res.slabs_released, o_out_data.slabs_released);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!stall_enable) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 99) < 65);
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("slab_object_allocator regression: fail");
            $finish;
        end
    end

    task automatic test_basic_ops();
        send_req(soa_pkg::OP_ALLOC, 0, 0, 0);
        send_req(soa_pkg::OP_ALLOC, 15, 1023, 31);
        send_req(soa_pkg::OP_FREE, 0, 63, 0);
        send_req(soa_pkg::OP_FREE, 0, 63, 0);
        send_req(soa_pkg::OP_FREE, 0, 62, 0);
        send_req(soa_pkg::OP_FREE, 0, 64, 0);
        send_req(soa_pkg::OP_FREE, 15, 1023, 0);
        send_req(soa_pkg::OP_FREE, 0, 63, 0);
        send_req(soa_pkg::OP_RECLAIM, 0, 0, 0);
        send_req(soa_pkg::OP_RECLAIM, 0, 0, 16);
        send_req(soa_pkg::OP_ALLOC, 0, 0, 0);
        send_req(soa_pkg::OP_DESTROY, 0, 0, 0);
        send_req(soa_pkg::OP_DESTROY, 10, 512, 21);
    endtask

    task automatic test_zero_size_and_big_stride();
        write_reg(soa_pkg::CFG_OBJECT_SIZE, 13'd0);
        send_req(soa_pkg::OP_ALLOC, 0, 0, 0);
        send_req(soa_pkg::OP_FREE, 0, 0, 0);
        write_reg(soa_pkg::CFG_OBJECT_SIZE, 13'd8191);
        send_req(soa_pkg::OP_ALLOC, 0, 0, 0);
        write_reg(soa_pkg::CFG_OBJECT_SIZE, 13'd4096);
        write_reg(soa_pkg::CFG_ALIGN_LOG2, 13'd12);
        send_req(soa_pkg::OP_ALLOC, 0, 0, 0);
        send_req(soa_pkg::OP_ALLOC, 0, 0, 0);
        send_req(soa_pkg::OP_FREE, 0, 0, 0);
        send_req(soa_pkg::OP_FREE, 1, 0, 0);
    endtask

    task automatic test_pool_exhaust();
        // capacity 2 per slab, so 32 allocations fill the pool
        write_reg(soa_pkg::CFG_OBJECT_SIZE, 13'd2048);
        write_reg(soa_pkg::CFG_ALIGN_LOG2, 13'd0);
        for (int i = 0; i < 34; i++) send_req(soa_pkg::OP_ALLOC, 0, 0, 0);
        for (int i = 0; i < 8; i++) send_req(soa_pkg::OP_FREE, i, i % 2, 0);
        send_req(soa_pkg::OP_RECLAIM, 0, 0, 3);
        send_req(soa_pkg::OP_DESTROY, 0, 0, 0);
    endtask

    task automatic test_random_mix(input int unsigned n_items);
        int unsigned r;
        logic [12:0] sizes[6] = '{13'd1, 13'd3, 13'd37, 13'd300, 13'd1000, 13'd2047};
        for (int p = 0; p < 6; p++) begin
            stall_enable = (p % 3 != 0);
            write_reg(soa_pkg::CFG_OBJECT_SIZE, sizes[p]);
            write_reg(soa_pkg::CFG_ALIGN_LOG2, 13'($urandom_range(0, 6)));
            // one setting per pass; live slabs are kept across every geometry change
            for (int i = 0; i < n_items / 6; i++) begin
                r = $urandom_range(0, 99);
                if (r < 45) send_req(soa_pkg::OP_ALLOC, $urandom, $urandom, $urandom);
                else if (r < 85) send_free_live();
                else if (r < 92) send_req(soa_pkg::OP_FREE, $urandom, $urandom, $urandom);
                else if (r < 98) send_req(soa_pkg::OP_RECLAIM, $urandom, $urandom,
                                          $urandom_range(0, 16));
                else send_req(soa_pkg::OP_DESTROY, $urandom, $urandom, $urandom);
            end
            if (p == 2) write_reg(soa_pkg::CFG_ALIGN_LOG2, 13'd2);
        end
        write_reg(soa_pkg::CFG_OBJECT_SIZE, 13'd4);
        write_reg(soa_pkg::CFG_ALIGN_LOG2, 13'd0);
        for (int i = 0; i < 20; i++) send_req(soa_pkg::OP_ALLOC, 0, 0, 0);
        send_req(soa_pkg::OP_FREE, 0, 1023, 0);
        send_req(soa_pkg::OP_RECLAIM, 0, 0, 31);
        send_req(soa_pkg::OP_DESTROY, 0, 0, 0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b1;
        i_cfg_we = 1'b0;
        i_cfg_index = soa_pkg::CFG_OBJECT_SIZE;
        i_cfg_data = '0;
        errors = 0;
        beats_sent = 0;
        beats_checked = 0;
        idle_cycles = 0;
        stall_enable = 1'b1;
        m_size = 13'd64;
        m_align = 4'd4;
        geometry_update();
        cache_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_zero_size_and_big_stride();
        test_pool_exhaust();
        test_random_mix(1560);
        wait_drain();

        $display("covered alloc, free, reclaim and destroy over %0d requests", beats_sent);
        $display("%0d results checked across sizes 0 to 8191 and alignments 0 to 12",
                 beats_checked);
        if (errors == 0 && pending_results.size() == 0)
            $display("slab_object_allocator regression: pass");
        else
            $display("slab_object_allocator regression: fail");
        $finish;
    end

endmodule

FILE: slab_object_allocator.f
rtl/core/soa_pkg.sv
rtl/core/slab_object_allocator.sv
sim/tb_slab_object_allocator.sv
